// ===== src/rqr_pkg.sv =====
// Package for the ready queue with removal.
// Holds command, status and sequencer codes and the default sizes.
// No dependencies.
package rqr_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_ID_WIDTH    = 8;

    // Fixed port widths of the command and result beats
    localparam int CMD_W       = 2;
    localparam int ID_PORT_W   = 8;
    localparam int STATUS_W    = 2;
    localparam int OCC_W       = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ    = 2'd0,
        CMD_DEQ    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ,
        S_DEQ_RD,
        S_DEQ_HEAD,
        S_WALK,
        S_RESP
    } state_t;

endpackage

// ===== src/rqr_mem.sv =====
// Entry store of the ready queue: one write port, one read port.
// Read data is registered. No reset: entries are undefined until written.
module rqr_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/rqr_slot.sv =====
// Circular slot address: (head + offset) mod DEPTH, offset below DEPTH.
// One add and one compare-and-subtract. No dependencies.
module rqr_slot #(
    parameter int DEPTH = 16
) (
    input  logic [$clog2(DEPTH)-1:0] head,
    input  logic [$clog2(DEPTH)-1:0] offset,
    output logic [$clog2(DEPTH)-1:0] slot
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW:0] DEPTH_W = (AW+1)'(DEPTH);

    logic [AW:0] sum;
    logic [AW:0] wrapped;

    always_comb
    begin
        sum = {1'b0, head} + {1'b0, offset};
        if (sum >= DEPTH_W)
        begin
            wrapped = sum - DEPTH_W;
        end
        else
        begin
            wrapped = sum;
        end
    end

    assign slot = wrapped[AW-1:0];

endmodule

// ===== src/ready_queue_with_removal.sv =====
// Ready queue with removal: top level, sequencer and pointer state.
// Uses rqr_pkg, rqr_mem (entry store) and rqr_slot (circular address unit).
//
// A command beat is taken when start is high and busy is low; the block then
// raises busy and works on that one command alone. Its single result beat
// appears for exactly one cycle with done high and must be captured then:
// there is no way to hold it off. Rejected or no-op commands, and a remove
// on an empty queue, go straight to the result; an enqueue first writes the
// entry, a dequeue first reads the head and then advances it, and any other
// remove first walks the queue. busy drops on the edge that ends the result
// cycle, so the next command may be taken there. The walk goes over the
// queue through the single read port of the entry store: one entry is read
// and compared per cycle, and entries behind the match are moved down one
// place through the write port in the same pass. The store needs no
// clearing after reset; only occupied entries are read.
module ready_queue_with_removal #(
    parameter int QUEUE_DEPTH = rqr_pkg::DEF_QUEUE_DEPTH,
    parameter int ID_WIDTH    = rqr_pkg::DEF_ID_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rqr_pkg::CMD_W-1:0]     command,
    input  logic [rqr_pkg::ID_PORT_W-1:0] thread_id,
    output logic                          done,
    output logic [rqr_pkg::ID_PORT_W-1:0] dispatched_id,
    output logic [rqr_pkg::STATUS_W-1:0]  status,
    output logic [rqr_pkg::OCC_W-1:0]     occupancy
);

    import rqr_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

    // Control state
    state_t        state_reg,    state_next;
    logic [CW-1:0] count_reg,    count_next;
    logic [AW-1:0] head_reg,     head_next;
    logic          data_vld_reg, data_vld_next;
    logic          found_reg,    found_next;

    // Payload
    logic [ID_WIDTH-1:0] id_reg,        id_next;
    logic [ID_WIDTH-1:0] disp_reg,      disp_next;
    status_t             status_reg,    status_next;
    logic [CW-1:0]       rd_off_reg,    rd_off_next;
    logic [AW-1:0]       data_addr_reg, data_addr_next;
    logic [AW-1:0]       prev_addr_reg, prev_addr_next;

    // Store and address unit
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [ID_WIDTH-1:0] mem_wdata;
    logic                mem_re;
    logic [ID_WIDTH-1:0] mem_rdata;
    logic [AW-1:0]       slot_off;
    logic [AW-1:0]       slot_addr;

    // Port width adaptation
    logic [ID_WIDTH+ID_PORT_W-1:0] id_in_wide;
    logic [ID_WIDTH+ID_PORT_W-1:0] disp_wide;
    logic [CW+OCC_W-1:0]           occ_wide;
    logic [ID_WIDTH-1:0]           id_in;

    assign id_in_wide = {{ID_WIDTH{1'b0}}, thread_id};
    assign id_in      = id_in_wide[ID_WIDTH-1:0];

    rqr_mem #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ID_WIDTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (slot_addr),
        .rdata (mem_rdata)
    );

    rqr_slot #(
        .DEPTH (QUEUE_DEPTH)
    ) u_slot (
        .head   (head_reg),
        .offset (slot_off),
        .slot   (slot_addr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            head_reg     <= '0;
            data_vld_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            head_reg     <= head_next;
            data_vld_reg <= data_vld_next;
            found_reg    <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg        <= id_next;
        disp_reg      <= disp_next;
        status_reg    <= status_next;
        rd_off_reg    <= rd_off_next;
        data_addr_reg <= data_addr_next;
        prev_addr_reg <= prev_addr_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        data_vld_next  = data_vld_reg;
        found_next     = found_reg;
        id_next        = id_reg;
        disp_next      = disp_reg;
        status_next    = status_reg;
        rd_off_next    = rd_off_reg;
        data_addr_next = data_addr_reg;
        prev_addr_next = prev_addr_reg;
        slot_off       = '0;
        mem_we         = 1'b0;
        mem_waddr      = slot_addr;
        mem_wdata      = id_reg;
        mem_re         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    id_next       = id_in;
                    disp_next     = '0;
                    rd_off_next   = '0;
                    data_vld_next = 1'b0;
                    found_next    = 1'b0;
                    case (cmd_t'(command))
                        CMD_ENQ:
                        begin
                            if (count_reg == FULL_COUNT)
                            begin
                                status_next = ST_FULL;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                status_next = ST_DONE;
                                state_next  = S_ENQ;
                            end
                        end
                        CMD_DEQ:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                status_next = ST_DONE;
                                state_next  = S_DEQ_RD;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            // not found until the walk proves otherwise
                            status_next = ST_NOTFOUND;
                            if (count_reg == '0)
                            begin
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                            status_next = ST_DONE;
                            state_next  = S_RESP;
                        end
                    endcase
                end
            end

            S_ENQ:
            begin
                slot_off   = count_reg[AW-1:0];
                mem_we     = 1'b1;
                mem_waddr  = slot_addr;
                mem_wdata  = id_reg;
                count_next = count_reg + CW'(1);
                state_next = S_RESP;
            end

            S_DEQ_RD:
            begin
                slot_off   = '0;
                mem_re     = 1'b1;
                state_next = S_DEQ_HEAD;
            end

            S_DEQ_HEAD:
            begin
                slot_off   = AW'(1);
                head_next  = slot_addr;
                disp_next  = mem_rdata;
                count_next = count_reg - CW'(1);
                state_next = S_RESP;
            end

            S_WALK:
            begin
                // compare stage: entry read last cycle
                slot_off = rd_off_reg[AW-1:0];
                if (data_vld_reg)
                begin
                    prev_addr_next = data_addr_reg;
                    if (found_reg)
                    begin
                        // close the gap: move entry down one place
                        mem_we    = 1'b1;
                        mem_waddr = prev_addr_reg;
                        mem_wdata = mem_rdata;
                    end
                    else if (mem_rdata == id_reg)
                    begin
                        found_next = 1'b1;
                    end
                end

                // read stage: next entry from the head
                if (rd_off_reg < count_reg)
                begin
                    mem_re         = 1'b1;
                    rd_off_next    = rd_off_reg + CW'(1);
                    data_addr_next = slot_addr;
                    data_vld_next  = 1'b1;
                end
                else
                begin
                    data_vld_next = 1'b0;
                end

                if (!data_vld_reg && (rd_off_reg == count_reg))
                begin
                    state_next = S_RESP;
                    if (found_reg)
                    begin
                        count_next  = count_reg - CW'(1);
                        status_next = ST_DONE;
                    end
                end
            end

            S_RESP:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign disp_wide = {{ID_PORT_W{1'b0}}, disp_reg};
    assign occ_wide  = {{OCC_W{1'b0}}, count_reg};

    assign busy          = (state_reg != S_IDLE);
    assign done          = (state_reg == S_RESP);
    assign dispatched_id = disp_wide[ID_PORT_W-1:0];
    assign status        = status_reg;
    assign occupancy     = occ_wide[OCC_W-1:0];

    // A walk only writes the store once the match has been seen
    a_walk_write_after_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && mem_we) |-> found_reg)
        else $error("store written during remove walk before a match");

    // Fill level never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("occupancy above queue depth");

    // A dequeue that takes the head drops the count by one
    a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DEQ_HEAD) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("dequeue did not drop occupancy by one");

    // A result beat is always followed by a return to idle
    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after result beat");

endmodule
